>>> src/a64dp_pkg.sv
// ----------------------------------------------------------------------------
// a64dp_pkg
// Shared types, decode codes and sizes for the A64 data-processing-immediate
// execute block.
// ----------------------------------------------------------------------------
package a64dp_pkg;

  localparam int NumRegs  = 31;
  localparam int RegIdxW  = 5;
  localparam int DataW    = 64;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // instruction class codes (bits 25:23)
  localparam logic [2:0] OPI_ADDSUB = 3'b010;
  localparam logic [2:0] OPI_MOVW   = 3'b101;

  // register 31: stack pointer or zero register depending on the form
  localparam logic [RegIdxW-1:0] REG_SP_ZR = 5'b11111;

  // wide move opcodes (bits 30:29)
  localparam logic [1:0] MOV_N = 2'b00;
  localparam logic [1:0] MOV_Z = 2'b10;
  localparam logic [1:0] MOV_K = 2'b11;

  localparam int Imm12Shift = 12;
  localparam int HwShift    = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CLASS = 2'd1,
    ST_BAD_OP    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_ADDSUB,
    CLS_MOVW,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    cls_t                cls;
    status_t             status;
    logic                sf;
    logic [1:0]          opc;
    logic                sh;
    logic [11:0]         imm12;
    logic [RegIdxW-1:0]  rn;
    logic [RegIdxW-1:0]  rd;
    logic [1:0]          hw;
    logic [15:0]         imm16;
  } dec_t;

endpackage

>>> src/a64dp_ram.sv
// ----------------------------------------------------------------------------
// a64dp_ram
// Generic single-write, single-read RAM with registered read data
// (read-first on a same-address write).
// ----------------------------------------------------------------------------
module a64dp_ram #(
  parameter int Width = 64,
  parameter int Depth = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/a64dp_decode.sv
// ----------------------------------------------------------------------------
// a64dp_decode
// Front end: splits an instruction word into its fields and classifies it
// as add/sub immediate, wide move, or unsupported.
// ----------------------------------------------------------------------------
module a64dp_decode (
  input  logic [31:0]     insn,
  output a64dp_pkg::dec_t dec
);

  import a64dp_pkg::*;

  logic [2:0] opi;

  assign opi = insn[25:23];

  always_comb begin
    dec        = '0;
    dec.sf     = insn[31];
    dec.opc    = insn[30:29];
    dec.sh     = insn[22];
    dec.imm12  = insn[21:10];
    dec.rn     = insn[9:5];
    dec.rd     = insn[4:0];
    dec.hw     = insn[22:21];
    dec.imm16  = insn[20:5];
    dec.cls    = CLS_NONE;
    dec.status = ST_BAD_CLASS;
    if (opi == OPI_ADDSUB) begin
      dec.cls    = CLS_ADDSUB;
      dec.status = ST_OK;
    end else if (opi == OPI_MOVW) begin
      // opc 01 has no wide move; upper halfwords need the 64-bit form
      if ((insn[30:29] != MOV_N && insn[30:29] != MOV_Z && insn[30:29] != MOV_K) ||
          (!insn[31] && insn[22])) begin
        dec.status = ST_BAD_OP;
      end else begin
        dec.cls    = CLS_MOVW;
        dec.status = ST_OK;
      end
    end
  end

endmodule

>>> src/a64dp_queue.sv
// ----------------------------------------------------------------------------
// a64dp_queue
// Short FIFO of decoded instructions between the front end and the
// execute back end; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module a64dp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  a64dp_pkg::dec_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output a64dp_pkg::dec_t head_data
);

  import a64dp_pkg::*;

  dec_t             slot_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] count_r;
  logic [QCntW-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == QCntW'(QDepth));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/a64dp_exec.sv
// ----------------------------------------------------------------------------
// a64dp_exec
// Back end: reads the register file, runs the add/sub or wide move,
// writes back registers, stack pointer and flags, and holds the result
// beat in an output register.
// ----------------------------------------------------------------------------
module a64dp_exec (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  a64dp_pkg::dec_t                  q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_write_enable,
  output logic [a64dp_pkg::RegIdxW-1:0]    out_dest_index,
  output logic [a64dp_pkg::DataW-1:0]      out_written_value,
  output logic                             out_flags_updated,
  output logic                             out_flag_negative,
  output logic                             out_flag_zero,
  output logic                             out_flag_carry,
  output logic                             out_flag_overflow,
  output logic [1:0]                       out_status
);

  import a64dp_pkg::*;

  // pipeline control
  logic               e2_valid_r;
  dec_t               e2_dec_r;
  logic               out_valid_r;
  logic               e2_adv;
  logic               pop;

  // architectural state
  logic [NumRegs-1:0] reg_valid_r;
  logic [DataW-1:0]   sp_r;
  logic [3:0]         nzcv_r;

  // read side
  logic [RegIdxW-1:0] rd_idx;
  logic               rd_live;
  logic               src_live_r;
  logic               fwd_hit_r;
  logic [DataW-1:0]   fwd_data_r;
  logic [DataW-1:0]   ram_rdata;
  logic [DataW-1:0]   src;

  // execute
  logic [DataW-1:0]   a_full;
  logic [DataW-1:0]   imm_ext;
  logic [DataW-1:0]   b_full;
  logic [DataW-1:0]   a_op;
  logic [DataW-1:0]   b_op;
  logic [DataW:0]     sum;
  logic [DataW-1:0]   as_res;
  logic               fl_n;
  logic               fl_z;
  logic               fl_c;
  logic               fl_v;
  logic [5:0]         shamt;
  logic [DataW-1:0]   mv_op;
  logic [DataW-1:0]   mv_mask;
  logic [DataW-1:0]   mv_raw;
  logic [DataW-1:0]   mv_res;
  logic [DataW-1:0]   res;
  logic               reg_we_c;
  logic               sp_we_c;
  logic               flags_we_c;
  logic               reg_we;

  // output register
  logic               out_we_r;
  logic [RegIdxW-1:0] out_dest_r;
  logic [DataW-1:0]   out_value_r;
  logic               out_fu_r;
  logic [3:0]         out_nzcv_r;
  status_t            out_status_r;

  assign e2_adv = e2_valid_r && (!out_valid_r || out_ready);
  assign pop    = q_valid && (!e2_valid_r || e2_adv);
  assign q_pop  = pop;

  // add/sub reads rn, movk reads rd as its old value
  assign rd_idx  = (q_data.cls == CLS_ADDSUB) ? q_data.rn : q_data.rd;
  assign rd_live = (rd_idx != REG_SP_ZR);

  a64dp_ram #(
    .Width (DataW),
    .Depth (NumRegs)
  ) u_regfile (
    .clk   (clk),
    .we    (reg_we),
    .waddr (e2_dec_r.rd),
    .wdata (res),
    .re    (pop && rd_live),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // a write landing on the read edge is not seen by the ram, so forward it
  always_ff @(posedge clk) begin
    if (pop) begin
      e2_dec_r   <= q_data;
      src_live_r <= rd_live && reg_valid_r[rd_idx];
      fwd_hit_r  <= rd_live && reg_we && (e2_dec_r.rd == rd_idx);
      fwd_data_r <= res;
    end
  end

  assign src = fwd_hit_r ? fwd_data_r : (src_live_r ? ram_rdata : '0);

  // add/sub immediate
  always_comb begin
    a_full  = (e2_dec_r.rn == REG_SP_ZR) ? sp_r : src;
    imm_ext = e2_dec_r.sh ? (DataW'(e2_dec_r.imm12) << Imm12Shift) : DataW'(e2_dec_r.imm12);
    b_full  = e2_dec_r.opc[1] ? ~imm_ext : imm_ext;
    a_op    = e2_dec_r.sf ? a_full : {32'b0, a_full[31:0]};
    b_op    = e2_dec_r.sf ? b_full : {32'b0, b_full[31:0]};
    sum     = {1'b0, a_op} + {1'b0, b_op} + (DataW+1)'(e2_dec_r.opc[1]);
    as_res  = e2_dec_r.sf ? sum[DataW-1:0] : {32'b0, sum[31:0]};
    if (e2_dec_r.sf) begin
      fl_c = sum[DataW];
      fl_n = as_res[63];
      fl_v = (a_op[63] ^ as_res[63]) & (b_op[63] ^ as_res[63]);
    end else begin
      fl_c = sum[32];
      fl_n = as_res[31];
      fl_v = (a_op[31] ^ as_res[31]) & (b_op[31] ^ as_res[31]);
    end
    fl_z = (as_res == '0);
  end

  // wide moves
  always_comb begin
    shamt   = 6'(e2_dec_r.hw * HwShift);
    mv_op   = DataW'(e2_dec_r.imm16) << shamt;
    mv_mask = DataW'(16'hFFFF) << shamt;
    unique case (e2_dec_r.opc)
      MOV_N:   mv_raw = ~mv_op;
      MOV_Z:   mv_raw = mv_op;
      default: mv_raw = (src & ~mv_mask) | mv_op;
    endcase
    mv_res = e2_dec_r.sf ? mv_raw : {32'b0, mv_raw[31:0]};
  end

  always_comb begin
    res        = '0;
    reg_we_c   = 1'b0;
    sp_we_c    = 1'b0;
    flags_we_c = 1'b0;
    unique case (e2_dec_r.cls)
      CLS_ADDSUB: begin
        res        = as_res;
        reg_we_c   = (e2_dec_r.rd != REG_SP_ZR);
        sp_we_c    = (e2_dec_r.rd == REG_SP_ZR) && !e2_dec_r.opc[0];
        flags_we_c = e2_dec_r.opc[0];
      end
      CLS_MOVW: begin
        res      = mv_res;
        reg_we_c = (e2_dec_r.rd != REG_SP_ZR);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign reg_we = e2_adv && reg_we_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reg_valid_r <= '0;
      sp_r        <= '0;
      nzcv_r      <= '0;
    end else begin
      if (pop) begin
        e2_valid_r <= 1'b1;
      end else if (e2_adv) begin
        e2_valid_r <= 1'b0;
      end
      if (e2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (reg_we) begin
        reg_valid_r[e2_dec_r.rd] <= 1'b1;
      end
      if (e2_adv && sp_we_c) begin
        sp_r <= res;
      end
      if (e2_adv && flags_we_c) begin
        nzcv_r <= {fl_n, fl_z, fl_c, fl_v};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e2_adv) begin
      out_we_r     <= reg_we_c || sp_we_c;
      out_dest_r   <= (reg_we_c || sp_we_c) ? e2_dec_r.rd : '0;
      out_value_r  <= (reg_we_c || sp_we_c) ? res : '0;
      out_fu_r     <= flags_we_c;
      out_nzcv_r   <= flags_we_c ? {fl_n, fl_z, fl_c, fl_v} : nzcv_r;
      out_status_r <= e2_dec_r.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_dest_index    = out_dest_r;
  assign out_written_value = out_value_r;
  assign out_flags_updated = out_fu_r;
  assign out_flag_negative = out_nzcv_r[3];
  assign out_flag_zero     = out_nzcv_r[2];
  assign out_flag_carry    = out_nzcv_r[1];
  assign out_flag_overflow = out_nzcv_r[0];
  assign out_status        = out_status_r;

endmodule

>>> src/a64_immediate_dp_execute_top.sv
// ----------------------------------------------------------------------------
// a64_immediate_dp_execute_top
// Executes A64 data-processing-immediate instructions (ADD/ADDS/SUB/SUBS
// immediate, MOVN/MOVZ/MOVK) against a 31 x 64-bit register file, SP and
// NZCV.
//
// Input channel in_valid/in_ready carries one instruction word per beat.
// Output channel out_valid/out_ready carries one result beat per
// instruction: write enable, destination, written value, flag update,
// NZCV after the instruction and a status code.
// Throughput is one instruction per cycle unless the output stalls; the
// register file read, the single 64-bit adder and writeback fit one
// execute stage, with writes forwarded to the following instruction.
// The result passes through the decode queue, the execute stage and the
// output register before out_valid rises.
// A two-entry queue sits between decode and execute, so input beats keep
// being taken while a result waits; when the receiver stalls, the output
// register, the execute stage and the queue fill, then in_ready drops.
// Reset (rst_n low, synchronous) empties the pipeline and clears SP, NZCV
// and all registers at once via per-register valid bits.
// ----------------------------------------------------------------------------
module a64_immediate_dp_execute_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_written_value,
  output logic        out_flags_updated,
  output logic        out_flag_negative,
  output logic        out_flag_zero,
  output logic        out_flag_carry,
  output logic        out_flag_overflow,
  output logic [1:0]  out_status
);

  import a64dp_pkg::*;

  dec_t dec;
  dec_t head_data;
  logic q_full;
  logic head_valid;
  logic q_pop;

  a64dp_decode u_decode (
    .insn (in_instruction_word),
    .dec  (dec)
  );

  assign in_ready = !q_full;

  a64dp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_data  (dec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  a64dp_exec u_exec (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (head_valid),
    .q_data            (head_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_dest_index    (out_dest_index),
    .out_written_value (out_written_value),
    .out_flags_updated (out_flags_updated),
    .out_flag_negative (out_flag_negative),
    .out_flag_zero     (out_flag_zero),
    .out_flag_carry    (out_flag_carry),
    .out_flag_overflow (out_flag_overflow),
    .out_status        (out_status)
  );

endmodule

>>> sim/a64dp_exec_checker.sv
// ----------------------------------------------------------------------------
// a64dp_exec_checker
// Watches both channels of the execute block, keeps its own register file,
// SP and NZCV, predicts one result per accepted instruction and compares
// every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module a64dp_exec_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_instruction_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_write_enable,
  input  logic [4:0]  out_dest_index,
  input  logic [63:0] out_written_value,
  input  logic        out_flags_updated,
  input  logic        out_flag_negative,
  input  logic        out_flag_zero,
  input  logic        out_flag_carry,
  input  logic        out_flag_overflow,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          results_owed,
  output int          results_checked,
  output int          flag_writes,
  output int          rejects
);

  import a64dp_pkg::*;

  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] dest;
    logic [DataW-1:0]   value;
    logic               fu;
    logic [3:0]         nzcv;
    status_t            status;
  } exec_result_t;

  logic [DataW-1:0] gpr [NumRegs];
  logic [DataW-1:0] sp;
  logic [3:0]       nzcv;
  exec_result_t     owed [$];
  int               errors = 0;
  int               checked = 0;
  int               nflags = 0;
  int               nrej = 0;

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch on result %0d: %s got %h, want %h", checked, field, got, want);
  endtask

  // executes one instruction on the local state and returns the result beat
  task automatic execute_insn(input logic [31:0] w, output exec_result_t r);
    logic             sf;
    logic [1:0]       opc;
    logic [2:0]       opi;
    logic [4:0]       rd;
    logic [4:0]       rn;
    logic [1:0]       hw;
    logic [DataW-1:0] opa;
    logic [DataW-1:0] opb;
    logic [DataW-1:0] imm;
    logic [DataW-1:0] res;
    logic [DataW-1:0] old;
    logic [DataW:0]   sum;
    logic             n;
    logic             c;
    logic             v;
    int               sh;

    r = '0;
    r.status = ST_OK;
    sf  = w[31];
    opc = w[30:29];
    opi = w[25:23];
    rd  = w[4:0];
    if (opi == OPI_ADDSUB) begin
      rn  = w[9:5];
      imm = {52'b0, w[21:10]};
      if (w[22]) imm = imm << Imm12Shift;
      opa = (rn == REG_SP_ZR) ? sp : gpr[rn];
      // subtract is a + not(imm) + 1
      opb = opc[1] ? ~imm : imm;
      if (!sf) begin
        sum = {33'b0, opa[31:0]} + {33'b0, opb[31:0]} + 65'(opc[1]);
        res = {32'b0, sum[31:0]};
        c   = sum[32];
        v   = (opa[31] ^ res[31]) & (opb[31] ^ res[31]);
        n   = res[31];
      end else begin
        sum = {1'b0, opa} + {1'b0, opb} + 65'(opc[1]);
        res = sum[63:0];
        c   = sum[64];
        v   = (opa[63] ^ res[63]) & (opb[63] ^ res[63]);
        n   = res[63];
      end
      if (rd == REG_SP_ZR) begin
        // flag-setting forms discard into the zero register
        if (!opc[0]) begin
          sp   = res;
          r.we = 1'b1;
        end
      end else begin
        gpr[rd] = res;
        r.we    = 1'b1;
      end
      if (r.we) begin
        r.dest  = rd;
        r.value = res;
      end
      if (opc[0]) begin
        nzcv = {n, (res == '0), c, v};
        r.fu = 1'b1;
      end
    end else if (opi == OPI_MOVW) begin
      hw  = w[22:21];
      sh  = hw * HwShift;
      imm = {48'b0, w[20:5]} << sh;
      if ((opc != MOV_N && opc != MOV_Z && opc != MOV_K) || (!sf && hw[1])) begin
        r.status = ST_BAD_OP;
      end else begin
        case (opc)
          MOV_N: res = ~imm;
          MOV_Z: res = imm;
          default: begin
            old = (rd == REG_SP_ZR) ? '0 : gpr[rd];
            res = (old & ~(64'hFFFF << sh)) | imm;
          end
        endcase
        if (!sf) res[63:32] = '0;
        if (rd != REG_SP_ZR) begin
          gpr[rd] = res;
          r.we    = 1'b1;
          r.dest  = rd;
          r.value = res;
        end
      end
    end else begin
      r.status = ST_BAD_CLASS;
    end
    r.nzcv = nzcv;
  endtask

  task automatic check_beat(input exec_result_t want);
    if (out_write_enable !== want.we)
      note_mismatch("write_enable", 64'(out_write_enable), 64'(want.we));
    if (out_dest_index !== want.dest)
      note_mismatch("dest_index", 64'(out_dest_index), 64'(want.dest));
    if (out_written_value !== want.value)
      note_mismatch("written_value", out_written_value, want.value);
    if (out_flags_updated !== want.fu)
      note_mismatch("flags_updated", 64'(out_flags_updated), 64'(want.fu));
    if (out_flag_negative !== want.nzcv[3])
      note_mismatch("flag_negative", 64'(out_flag_negative), 64'(want.nzcv[3]));
    if (out_flag_zero !== want.nzcv[2])
      note_mismatch("flag_zero", 64'(out_flag_zero), 64'(want.nzcv[2]));
    if (out_flag_carry !== want.nzcv[1])
      note_mismatch("flag_carry", 64'(out_flag_carry), 64'(want.nzcv[1]));
    if (out_flag_overflow !== want.nzcv[0])
      note_mismatch("flag_overflow", 64'(out_flag_overflow), 64'(want.nzcv[0]));
    if (out_status !== want.status)
      note_mismatch("status", 64'(out_status), 64'(want.status));
  endtask

  always @(posedge clk) begin : monitor
    exec_result_t predicted;
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
      sp   = '0;
      nzcv = '0;
      owed.delete();
    end else begin
      // result side first: a beat accepted now cannot belong to this edge's input
      if (out_valid && out_ready) begin
        if (owed.size() == 0) begin
          note_mismatch("result beat with nothing owed", out_written_value, '0);
        end else begin
          check_beat(owed.pop_front());
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        execute_insn(in_instruction_word, predicted);
        owed.push_back(predicted);
        if (predicted.fu) nflags++;
        if (predicted.status != ST_OK) nrej++;
      end
    end
    fail_count      <= errors;
    results_owed    <= owed.size();
    results_checked <= checked;
    flag_writes     <= nflags;
    rejects         <= nrej;
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for a64_immediate_dp_execute_top. Sends directed corner cases of
// add/sub, wide moves and other classes, then random instruction streams under
// several sender idle and receiver stall mixes, including one long output stall that
// backs the pipeline up. Checking is done by a64dp_exec_checker.
// ----------------------------------------------------------------------------
module tb;
  import a64dp_pkg::*;

  localparam int LimitCycles    = 300000;
  localparam int HoldCycles     = 120;
  localparam int TailCycles     = 8;
  localparam int ItemsPerPhase  = 357;
  localparam int MaxGap         = 40;

  // add/sub immediate opcodes (bits 30:29)
  localparam logic [1:0] OP_ADD  = 2'b00;
  localparam logic [1:0] OP_ADDS = 2'b01;
  localparam logic [1:0] OP_SUB  = 2'b10;
  localparam logic [1:0] OP_SUBS = 2'b11;
  // wide move opcode with no instruction behind it
  localparam logic [1:0] MOV_RSVD = 2'b01;
  // a class outside the block's scope
  localparam logic [2:0] OPI_BITFIELD = 3'b110;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_write_enable;
  logic [4:0]  out_dest_index;
  logic [63:0] out_written_value;
  logic        out_flags_updated;
  logic        out_flag_negative;
  logic        out_flag_zero;
  logic        out_flag_carry;
  logic        out_flag_overflow;
  logic [1:0]  out_status;

  int fail_count;
  int results_owed;
  int results_checked;
  int flag_writes;
  int rejects;

  int hold_tag = 0;
  int recv_stall = 0;
  int n_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  a64_immediate_dp_execute_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_write_enable    (out_write_enable),
    .out_dest_index      (out_dest_index),
    .out_written_value   (out_written_value),
    .out_flags_updated   (out_flags_updated),
    .out_flag_negative   (out_flag_negative),
    .out_flag_zero       (out_flag_zero),
    .out_flag_carry      (out_flag_carry),
    .out_flag_overflow   (out_flag_overflow),
    .out_status          (out_status)
  );

  a64dp_exec_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_write_enable    (out_write_enable),
    .out_dest_index      (out_dest_index),
    .out_written_value   (out_written_value),
    .out_flags_updated   (out_flags_updated),
    .out_flag_negative   (out_flag_negative),
    .out_flag_zero       (out_flag_zero),
    .out_flag_carry      (out_flag_carry),
    .out_flag_overflow   (out_flag_overflow),
    .out_status          (out_status),
    .fail_count          (fail_count),
    .results_owed        (results_owed),
    .results_checked     (results_checked),
    .flag_writes         (flag_writes),
    .rejects             (rejects)
  );

  function automatic logic [31:0] addsub_word(input logic sf, input logic [1:0] opc,
                                              input logic sh, input logic [11:0] imm12,
                                              input logic [4:0] rn, input logic [4:0] rd);
    return {sf, opc, 3'b100, OPI_ADDSUB, sh, imm12, rn, rd};
  endfunction

  function automatic logic [31:0] movw_word(input logic sf, input logic [1:0] opc,
                                            input logic [1:0] hw, input logic [15:0] imm16,
                                            input logic [4:0] rd);
    return {sf, opc, 3'b100, OPI_MOVW, hw, imm16, rd};
  endfunction

  // a few low registers most of the time so values build on each other
  function automatic logic [4:0] pick_reg();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return REG_SP_ZR;
    if (k < 80) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 30));
  endfunction

  function automatic logic [31:0] rand_insn();
    int          kind;
    logic        sf;
    logic        sh;
    logic [1:0]  opc;
    logic [1:0]  hw;
    logic [11:0] imm12;
    logic [15:0] imm16;
    logic [31:0] w;
    kind = $urandom_range(0, 99);
    sf   = ($urandom_range(0, 99) < 55);
    if (kind < 48) begin
      opc = 2'($urandom_range(0, 3));
      sh  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 6))
        0:       imm12 = '0;
        1:       imm12 = '1;
        2:       imm12 = 12'h001;
        default: imm12 = 12'($urandom);
      endcase
      w = addsub_word(sf, opc, sh, imm12, pick_reg(), pick_reg());
    end else if (kind < 88) begin
      if ($urandom_range(0, 9) == 0) begin
        opc = MOV_RSVD;
      end else begin
        case ($urandom_range(0, 2))
          0:       opc = MOV_N;
          1:       opc = MOV_Z;
          default: opc = MOV_K;
        endcase
      end
      hw = 2'($urandom_range(0, 3));
      if (!sf && $urandom_range(0, 9) != 0) hw[1] = 1'b0;
      case ($urandom_range(0, 7))
        0:       imm16 = '0;
        1:       imm16 = '1;
        2:       imm16 = 16'h8000;
        default: imm16 = 16'($urandom);
      endcase
      w = movw_word(sf, opc, hw, imm16, pick_reg());
    end else begin
      w = $urandom;
    end
    // bits 28:26 are ignored by the block, so shake them now and then
    if (kind < 88 && $urandom_range(0, 9) == 0) w[28:26] = 3'($urandom_range(0, 7));
    return w;
  endfunction

  // optional idle gap, then offer the beat until it is taken
  task automatic send_insn(input logic [31:0] w, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_instruction_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
    recv_stall <= stall_pct;
    for (int k = 0; k < count; k++) send_insn(rand_insn(), idle_pct);
  endtask

  // receiver: random stalls, plus a long hold-off whenever hold_tag moves
  initial begin : receiver
    int hold_left;
    int seen_tag;
    hold_left = 0;
    seen_tag  = 0;
    forever begin
      @(posedge clk);
      if (hold_tag != seen_tag) begin
        seen_tag  = hold_tag;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] w;
    logic [31:0] directed [$];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(addsub_word(1'b1, OP_ADD, 1'b0, 12'hFFF, REG_SP_ZR, 5'd1));
    directed.push_back(addsub_word(1'b1, OP_ADD, 1'b1, 12'hFFF, 5'd1, REG_SP_ZR));
    directed.push_back(addsub_word(1'b1, OP_SUBS, 1'b0, 12'h001, REG_SP_ZR, 5'd2));
    directed.push_back(movw_word(1'b1, MOV_N, 2'd0, 16'h0000, 5'd4));
    // carry out and zero from all ones plus one
    directed.push_back(addsub_word(1'b1, OP_ADDS, 1'b0, 12'h001, 5'd4, 5'd5));
    directed.push_back(addsub_word(1'b0, OP_SUBS, 1'b0, 12'h001, 5'd0, 5'd6));
    directed.push_back(movw_word(1'b1, MOV_Z, 2'd3, 16'h8000, 5'd7));
    // signed overflow at 64 and 32 bits
    directed.push_back(addsub_word(1'b1, OP_SUBS, 1'b0, 12'h001, 5'd7, 5'd8));
    directed.push_back(movw_word(1'b0, MOV_Z, 2'd1, 16'h7FFF, 5'd9));
    directed.push_back(addsub_word(1'b0, OP_ADDS, 1'b1, 12'h010, 5'd9, 5'd10));
    // compare forms: flags only, nothing written
    directed.push_back(addsub_word(1'b1, OP_ADDS, 1'b0, 12'hFFF, 5'd4, REG_SP_ZR));
    directed.push_back(addsub_word(1'b0, OP_SUBS, 1'b1, 12'hFFF, 5'd1, REG_SP_ZR));
    directed.push_back(movw_word(1'b1, MOV_K, 2'd0, 16'h1234, 5'd7));
    directed.push_back(movw_word(1'b0, MOV_K, 2'd1, 16'hABCD, 5'd4));
    directed.push_back(movw_word(1'b1, MOV_K, 2'd2, 16'hFFFF, REG_SP_ZR));
    directed.push_back(movw_word(1'b0, MOV_N, 2'd0, 16'hFFFF, 5'd11));
    // rejected wide moves
    directed.push_back(movw_word(1'b1, MOV_RSVD, 2'd0, 16'h5555, 5'd12));
    directed.push_back(movw_word(1'b0, MOV_Z, 2'd2, 16'h1111, 5'd12));
    directed.push_back(movw_word(1'b0, MOV_N, 2'd3, 16'h2222, 5'd12));
    directed.push_back(32'h0000_0000);
    directed.push_back(32'hFFFF_FFFF);
    w = addsub_word(1'b1, OP_ADD, 1'b0, 12'h123, 5'd1, 5'd13);
    w[25:23] = OPI_BITFIELD;
    directed.push_back(w);
    directed.push_back(addsub_word(1'b0, OP_ADD, 1'b0, 12'h001, 5'd4, REG_SP_ZR));
    directed.push_back(addsub_word(1'b1, OP_SUB, 1'b1, 12'h800, REG_SP_ZR, 5'd30));
    w = addsub_word(1'b1, OP_ADDS, 1'b0, 12'h7FF, 5'd30, 5'd3);
    w[28:26] = 3'b011;
    directed.push_back(w);
    foreach (directed[i]) send_insn(directed[i], 0);

    // back-to-back with a long output stall so the pipe fills and in_ready drops
    hold_tag <= hold_tag + 1;
    run_phase(ItemsPerPhase, 0, 0);
    run_phase(ItemsPerPhase, 62, 0);
    run_phase(ItemsPerPhase, 0, 62);
    run_phase(ItemsPerPhase, 30, 30);

    in_valid   <= 1'b0;
    recv_stall <= 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("sent %0d instructions: directed corner cases, then random streams", n_sent);
    $display("checked %0d results (%0d flag updates, %0d rejected)",
             results_checked, flag_writes, rejects);
    $display("  under idle, stall and backpressure");
    if (fail_count == 0) begin
      $display("PASS a64_immediate_dp_execute_top");
    end else begin
      $display("FAIL a64_immediate_dp_execute_top");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitCycles * 10);
    $display("timeout with %0d results still owed", results_owed);
    $display("FAIL a64_immediate_dp_execute_top");
    $finish;
  end

endmodule

>>> filelist.f
src/a64dp_pkg.sv
src/a64dp_ram.sv
src/a64dp_decode.sv
src/a64dp_queue.sv
src/a64dp_exec.sv
src/a64_immediate_dp_execute_top.sv
sim/a64dp_exec_checker.sv
sim/tb.sv
